@@ rtl/serial_command_token_matcher_macros.svh @@
// Assertion helpers shared by the matcher modules
`ifndef SERIAL_COMMAND_TOKEN_MATCHER_MACROS_SVH
`define SERIAL_COMMAND_TOKEN_MATCHER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SCMT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SCMT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/scmt_pkg.sv @@
package scmt_pkg;

    // character codes
    localparam logic [7:0] NUL_CHAR   = 8'd0;
    localparam logic [7:0] SPACE_CHAR = 8'd32;
    localparam logic [7:0] END_CHAR   = 8'd59;

    // configuration register map
    localparam int CFG_W      = 64;
    localparam int REG_IDX_W  = 3;
    localparam int COUNT_W    = 3;
    localparam int INDEX_W    = 3;
    localparam int WORD_COUNT = 7;

    localparam logic [REG_IDX_W-1:0] REG_COMMAND_COUNT = 3'd0;

    // parameter defaults
    localparam int BUFFER_SIZE_DEF   = 64;
    localparam int COMMAND_CHARS_DEF = 8;

    // line status handed to the matcher
    typedef struct packed {
        logic eol;
        logic present;
    } line_ev_t;

    // one result word
    typedef struct packed {
        logic               token_present;
        logic               matched;
        logic [INDEX_W-1:0] command_index;
    } result_t;

endpackage

@@ rtl/scmt_line.sv @@
`include "serial_command_token_matcher_macros.svh"

module scmt_line #(
    parameter int BUFFER_SIZE   = scmt_pkg::BUFFER_SIZE_DEF,
    parameter int COMMAND_CHARS = scmt_pkg::COMMAND_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         byte_acc,
    input  logic [7:0]                   rx_byte,
    output scmt_pkg::line_ev_t           line_ev,
    output logic [8*COMMAND_CHARS-1:0]   token_chars,
    output logic [$clog2(COMMAND_CHARS+1)-1:0] token_len
);

    localparam int FILL_W = $clog2(BUFFER_SIZE + 1);
    localparam int LEN_W  = $clog2(COMMAND_CHARS + 1);
    localparam int TOK_W  = 8 * COMMAND_CHARS;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_TOKEN,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [TOK_W-1:0]   chars_reg, chars_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic is_nul, is_end, is_space, has_room;

    assign is_nul   = (rx_byte == scmt_pkg::NUL_CHAR);
    assign is_end   = (rx_byte == scmt_pkg::END_CHAR);
    assign is_space = (rx_byte == scmt_pkg::SPACE_CHAR);
    assign has_room = (fill_reg < FILL_W'(BUFFER_SIZE));

    // line state update for one accepted word
    always_comb begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        chars_next = chars_reg;
        len_next   = len_reg;
        if (byte_acc && !is_nul) begin
            if (is_end) begin
                phase_next = PH_SKIP;
                fill_next  = '0;
                chars_next = '0;
                len_next   = '0;
            end else if (has_room) begin
                fill_next = fill_reg + FILL_W'(1);
                if (is_space) begin
                    if (phase_reg == PH_TOKEN) begin
                        phase_next = PH_DONE;
                    end
                end else if (phase_reg != PH_DONE) begin
                    phase_next = PH_TOKEN;
                    if (len_reg < LEN_W'(COMMAND_CHARS)) begin
                        // drop the character into its byte lane
                        for (int k = 0; k < COMMAND_CHARS; k++) begin
                            if (len_reg == LEN_W'(k)) begin
                                chars_next[8*k +: 8] = rx_byte;
                            end
                        end
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            fill_reg  <= '0;
            chars_reg <= '0;
            len_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            chars_reg <= chars_next;
            len_reg   <= len_next;
        end
    end

    // view of the line before this word
    assign line_ev.eol     = byte_acc && is_end;
    assign line_ev.present = (phase_reg != PH_SKIP);
    assign token_chars     = chars_reg;
    assign token_len       = len_reg;

    `SCMT_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LEN_W'(COMMAND_CHARS), "token length overrun")
    `SCMT_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(BUFFER_SIZE), "fill count overrun")
    `SCMT_ASSERT_IMP(a_skip_empty, aclk, aresetn, phase_reg == PH_SKIP, len_reg == '0 && chars_reg == '0, "token held while skipping")
    `SCMT_ASSERT_NXT(a_eol_clear, aclk, aresetn, byte_acc && is_end, fill_reg == '0 && phase_reg == PH_SKIP, "line not cleared")

endmodule

@@ rtl/scmt_match.sv @@
module scmt_match #(
    parameter int COMMAND_CHARS = scmt_pkg::COMMAND_CHARS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [scmt_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [scmt_pkg::CFG_W-1:0]            cfg_wdata,
    input  scmt_pkg::line_ev_t                    line_ev,
    input  logic [8*COMMAND_CHARS-1:0]            token_chars,
    input  logic [$clog2(COMMAND_CHARS+1)-1:0]    token_len,
    output logic                                  res_valid,
    output scmt_pkg::result_t                     res
);

    localparam int LEN_W = $clog2(COMMAND_CHARS + 1);
    localparam int TOK_W = 8 * COMMAND_CHARS;

    logic [scmt_pkg::COUNT_W-1:0] count_reg;
    logic [TOK_W-1:0]             word_reg [scmt_pkg::WORD_COUNT];
    logic [scmt_pkg::WORD_COUNT-1:0] hit;
    logic [scmt_pkg::REG_IDX_W-1:0]  word_sel;

    assign word_sel = cfg_index - scmt_pkg::REG_IDX_W'(1);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < scmt_pkg::WORD_COUNT; i++) begin
                word_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == scmt_pkg::REG_COMMAND_COUNT) begin
                count_reg <= cfg_wdata[scmt_pkg::COUNT_W-1:0];
            end else begin
                word_reg[word_sel] <= cfg_wdata[TOK_W-1:0];
            end
        end
    end

    // one comparator per command word; lanes up to and including the
    // token terminator must agree
    always_comb begin
        for (int i = 0; i < scmt_pkg::WORD_COUNT; i++) begin
            hit[i] = (scmt_pkg::COUNT_W'(i) < count_reg);
            for (int k = 0; k < COMMAND_CHARS; k++) begin
                if ((LEN_W'(k) <= token_len) &&
                    (token_chars[8*k +: 8] != word_reg[i][8*k +: 8])) begin
                    hit[i] = 1'b0;
                end
            end
        end
    end

    // lowest matching index wins
    always_comb begin
        res               = '0;
        res.token_present = line_ev.present;
        for (int i = scmt_pkg::WORD_COUNT - 1; i >= 0; i--) begin
            if (line_ev.present && hit[i]) begin
                res.matched       = 1'b1;
                res.command_index = scmt_pkg::INDEX_W'(i);
            end
        end
    end

    assign res_valid = line_ev.eol;

endmodule

@@ rtl/scmt_out.sv @@
`include "serial_command_token_matcher_macros.svh"

module scmt_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  scmt_pkg::result_t in_res,
    output logic              in_space,
    output logic              m_valid,
    input  logic              m_ready,
    output scmt_pkg::result_t m_res
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    scmt_pkg::result_t main_reg, main_next;
    scmt_pkg::result_t skid_reg, skid_next;
    logic              take;

    assign take = main_valid_reg && m_ready;

    // output register backed by one skid word
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_next       = in_res;
            end
        end else if (!main_valid_reg) begin
            main_valid_next = in_valid;
            main_next       = in_res;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_space = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_res    = main_reg;

    `SCMT_ASSERT_IMP(a_skid_order, aclk, aresetn, skid_valid_reg, main_valid_reg, "skid word without output word")
    `SCMT_ASSERT_IMP(a_no_overflow, aclk, aresetn, in_valid, !skid_valid_reg, "result with both words full")
    `SCMT_ASSERT_NXT(a_fill_empty, aclk, aresetn, !main_valid_reg && in_valid, main_valid_reg, "result lost")
    `SCMT_ASSERT_IMP(a_match_token, aclk, aresetn, main_valid_reg && main_reg.matched, main_reg.token_present, "match without token")
    `SCMT_ASSERT_IMP(a_index_zero, aclk, aresetn, main_valid_reg && !main_reg.matched, main_reg.command_index == '0, "index set without match")

endmodule

@@ rtl/serial_command_token_matcher.sv @@
// Each ';' result is registered in the output register, or the skid word if that stalls.
// One byte per cycle while s_ready is high; bytes share no state but the line register set.
// s_ready drops only while two results wait at the output (output register plus skid word).
// Reset (aresetn low, synchronous): line cleared, command count and words zeroed,
// no result pending.
module serial_command_token_matcher #(
    parameter int BUFFER_SIZE   = scmt_pkg::BUFFER_SIZE_DEF,
    parameter int COMMAND_CHARS = scmt_pkg::COMMAND_CHARS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_token_present,
    output logic                                 m_matched,
    output logic [scmt_pkg::INDEX_W-1:0]         m_command_index,
    input  logic                                 cfg_wr_en,
    input  logic [scmt_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [scmt_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int LEN_W = $clog2(COMMAND_CHARS + 1);

    logic                       byte_acc;
    scmt_pkg::line_ev_t         line_ev;
    logic [8*COMMAND_CHARS-1:0] token_chars;
    logic [LEN_W-1:0]           token_len;
    logic                       res_valid;
    scmt_pkg::result_t          res;
    scmt_pkg::result_t          m_res;
    logic                       out_space;

    assign s_ready  = out_space;
    assign byte_acc = s_valid && s_ready;

    scmt_line #(
        .BUFFER_SIZE   (BUFFER_SIZE),
        .COMMAND_CHARS (COMMAND_CHARS)
    ) u_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_acc    (byte_acc),
        .rx_byte     (s_rx_byte),
        .line_ev     (line_ev),
        .token_chars (token_chars),
        .token_len   (token_len)
    );

    scmt_match #(
        .COMMAND_CHARS (COMMAND_CHARS)
    ) u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .line_ev     (line_ev),
        .token_chars (token_chars),
        .token_len   (token_len),
        .res_valid   (res_valid),
        .res         (res)
    );

    scmt_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .in_space (out_space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_token_present = m_res.token_present;
    assign m_matched       = m_res.matched;
    assign m_command_index = m_res.command_index;

endmodule

@@ dv/tb_serial_command_token_matcher.sv @@
`timescale 1ns / 1ps

module tb_serial_command_token_matcher;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_IDLE      = 13;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET   = 950;
    localparam int LINE_BYTES    = scmt_pkg::BUFFER_SIZE_DEF;
    localparam int NAME_CHARS    = scmt_pkg::COMMAND_CHARS_DEF;

    localparam logic [scmt_pkg::REG_IDX_W-1:0] REG_WORD_FIRST =
        scmt_pkg::REG_COMMAND_COUNT + 3'd1;

    typedef enum logic [1:0] {PH_LEAD, PH_TOKEN, PH_AFTER} line_phase_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [7:0]                     s_rx_byte;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_token_present;
    logic                           m_matched;
    logic [scmt_pkg::INDEX_W-1:0]   m_command_index;
    logic                           cfg_wr_en;
    logic [scmt_pkg::REG_IDX_W-1:0] cfg_index;
    logic [scmt_pkg::CFG_W-1:0]     cfg_wdata;

    // shadow of the command registers and the line being parsed
    logic [scmt_pkg::COUNT_W-1:0] active_count;
    logic [63:0]                  command_words [scmt_pkg::WORD_COUNT];
    logic [63:0]                  staged_words [scmt_pkg::WORD_COUNT];
    int                           line_fill;
    line_phase_t                  line_phase;
    logic [63:0]                  token_bytes;
    int                           token_len;

    scmt_pkg::result_t expected_verdicts [$];
    int                mismatches;
    int                bytes_used;
    bit                send_fast;
    bit                recv_fast;

    serial_command_token_matcher u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_present (m_token_present),
        .m_matched       (m_matched),
        .m_command_index (m_command_index),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------
    // Line parser prediction
    // ---------------------------------------------------------------
    function automatic void clear_line();
        line_fill   = 0;
        line_phase  = PH_LEAD;
        token_bytes = '0;
        token_len   = 0;
    endfunction

    // byte-wise compare, equal once both sides reach a zero byte
    function automatic bit token_equals_word(input logic [63:0] tok,
                                             input logic [63:0] word);
        logic [7:0] t;
        logic [7:0] w;
        for (int k = 0; k < NAME_CHARS; k++) begin
            t = tok[8*k +: 8];
            w = word[8*k +: 8];
            if (t != w) return 1'b0;
            if (t == scmt_pkg::NUL_CHAR) return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        scmt_pkg::result_t verdict;
        if (b == scmt_pkg::NUL_CHAR) return;
        if (b == scmt_pkg::END_CHAR) begin
            verdict = '0;
            verdict.token_present = (line_phase != PH_LEAD);
            if (verdict.token_present) begin
                for (int i = 0; i < active_count && !verdict.matched; i++) begin
                    if (token_equals_word(token_bytes, command_words[i])) begin
                        verdict.matched       = 1'b1;
                        verdict.command_index = scmt_pkg::INDEX_W'(i);
                    end
                end
            end
            expected_verdicts.push_back(verdict);
            clear_line();
            return;
        end
        // line buffer full: byte dropped
        if (line_fill >= LINE_BYTES) return;
        line_fill++;
        if (b == scmt_pkg::SPACE_CHAR) begin
            if (line_phase == PH_TOKEN) line_phase = PH_AFTER;
        end else if (line_phase != PH_AFTER) begin
            line_phase = PH_TOKEN;
            if (token_len < NAME_CHARS) begin
                token_bytes[8*token_len +: 8] = b;
                token_len++;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        scmt_pkg::result_t want;
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0b/%0b/%0d", $time,
                         m_token_present, m_matched, m_command_index);
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                check_field("token_present", want.token_present, m_token_present);
                check_field("matched", want.matched, m_matched);
                check_field("command_index", want.command_index, m_command_index);
            end
        end
    end

    // result sink with random back-pressure
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = recv_fast ? 0 : $urandom_range(MAX_IDLE, 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_fast ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_used++;
        parse_rx_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic send_repeat(input logic [7:0] b, input int n);
        repeat (n) send_byte(b);
    endtask

    // sender stops and waits until every result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes the count register and all seven words from staged_words
    task automatic load_commands(input int count);
        logic [63:0] data;
        data = {$urandom, $urandom};
        data[scmt_pkg::COUNT_W-1:0] = scmt_pkg::COUNT_W'(count);
        cfg_wr_en <= 1'b1;
        cfg_index <= scmt_pkg::REG_COMMAND_COUNT;
        cfg_wdata <= data;
        @(posedge aclk);
        active_count = data[scmt_pkg::COUNT_W-1:0];
        for (int i = 0; i < scmt_pkg::WORD_COUNT; i++) begin
            cfg_index <= scmt_pkg::REG_IDX_W'(REG_WORD_FIRST + i);
            cfg_wdata <= staged_words[i];
            @(posedge aclk);
            command_words[i] = staged_words[i];
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] text_word(input string s);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < s.len() && k < 8; k++) w[8*k +: 8] = s[k];
        return w;
    endfunction

    // printable, never a space or a line end
    function automatic logic [7:0] random_name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(126, 33)); while (c == scmt_pkg::END_CHAR);
        return c;
    endfunction

    // any token byte, high codes included
    function automatic logic [7:0] random_wide_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255, 1));
        while (c == scmt_pkg::SPACE_CHAR || c == scmt_pkg::END_CHAR);
        return c;
    endfunction

    function automatic logic [63:0] random_name(input int len);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < len; k++) w[8*k +: 8] = random_name_char();
        return w;
    endfunction

    task automatic load_random_commands();
        int pick;
        for (int i = 0; i < scmt_pkg::WORD_COUNT; i++) begin
            pick = $urandom_range(9, 0);
            if (pick < 7)       staged_words[i] = random_name($urandom_range(8, 1));
            else if (pick == 7) staged_words[i] = '0;
            else if (pick == 8) staged_words[i] = {$urandom, $urandom};
            else if (i > 0)     staged_words[i] = staged_words[$urandom_range(i - 1, 0)];
            else                staged_words[i] = '1;
        end
        load_commands($urandom_range(7, 0));
    endtask

    // one ';'-terminated line, token taken from any loaded command word in half the lines
    task automatic send_random_line();
        logic [7:0]  line [$];
        logic [63:0] w;
        int          lead;
        int          kind;
        int          nul_at;
        lead = ($urandom_range(19, 0) == 0) ? $urandom_range(70, 50) : $urandom_range(3, 0);
        repeat (lead) line.push_back(scmt_pkg::SPACE_CHAR);
        kind = $urandom_range(9, 0);
        if (kind <= 4) begin
            w = command_words[$urandom_range(scmt_pkg::WORD_COUNT - 1, 0)];
            for (int k = 0; k < NAME_CHARS && w[8*k +: 8] != scmt_pkg::NUL_CHAR; k++)
                line.push_back(w[8*k +: 8]);
            // near misses: longer token, or last character changed
            if (kind == 4)
                repeat ($urandom_range(3, 1)) line.push_back(random_name_char());
            else if (kind == 3 && line.size() > lead)
                line[line.size() - 1] = random_name_char();
        end else if (kind <= 7) begin
            repeat ($urandom_range(12, 1)) line.push_back(random_name_char());
        end else if (kind == 8) begin
            repeat ($urandom_range(12, 1)) line.push_back(random_wide_char());
        end
        // arguments after the token
        repeat ($urandom_range(2, 0)) begin
            line.push_back(scmt_pkg::SPACE_CHAR);
            repeat ($urandom_range(5, 1)) line.push_back(random_name_char());
        end
        nul_at = ($urandom_range(7, 0) == 0) ? $urandom_range(line.size(), 0) : -1;
        line.push_back(scmt_pkg::END_CHAR);
        for (int k = 0; k < line.size(); k++) begin
            if (k == nul_at) send_byte(scmt_pkg::NUL_CHAR);
            send_byte(line[k]);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // count is zero after reset: a token never matches
    task automatic test_after_reset();
        send_text("go;");
        drain_results();
    endtask

    task automatic test_directed_lines();
        staged_words[0] = text_word("go");
        staged_words[1] = text_word("stop");
        staged_words[2] = '0;
        staged_words[3] = text_word("abcdefgh");
        staged_words[4] = text_word("a") | (text_word("xyz") << 16);
        staged_words[5] = '1;
        staged_words[6] = text_word("stop");
        load_commands(scmt_pkg::WORD_COUNT);
        // empty line and a line of spaces only
        send_text(";");
        send_text(" ;");
        // leading space with an ignored zero byte inside the token
        send_byte(scmt_pkg::SPACE_CHAR);
        send_byte("g");
        send_byte(scmt_pkg::NUL_CHAR);
        send_text("o;");
        // token longer than a command word
        send_text("abcdefghi;");
        // word cut short by a zero byte
        send_text("a;");
        // duplicate word: lowest index wins
        send_text("stop;");
        drain_results();
    endtask

    task automatic test_line_overflow();
        staged_words[0] = text_word("g");
        staged_words[1] = text_word("abcdefgh");
        for (int i = 2; i < scmt_pkg::WORD_COUNT; i++) staged_words[i] = '0;
        load_commands(2);
        // only the first character of the token still fits
        send_repeat(scmt_pkg::SPACE_CHAR, LINE_BYTES - 1);
        send_text("go;");
        // token starts past the end of the buffer
        send_repeat(scmt_pkg::SPACE_CHAR, LINE_BYTES);
        send_text("go;");
        // long line, token at the start
        send_text("abcdefgh");
        send_repeat("z", LINE_BYTES);
        send_text(";");
        // zero bytes do not take buffer space
        send_repeat(scmt_pkg::SPACE_CHAR, 30);
        send_byte(scmt_pkg::NUL_CHAR);
        send_repeat(scmt_pkg::SPACE_CHAR, LINE_BYTES - 31);
        send_text("go;");
        // next line starts clean
        send_text("go;");
        drain_results();
    endtask

    task automatic test_command_settings();
        // no active words
        load_random_commands();
        load_commands(0);
        repeat (10) send_random_line();
        drain_results();
        // all words all ones
        for (int i = 0; i < scmt_pkg::WORD_COUNT; i++) staged_words[i] = '1;
        load_commands(scmt_pkg::WORD_COUNT);
        repeat (10) send_random_line();
        drain_results();
        // all words zero
        for (int i = 0; i < scmt_pkg::WORD_COUNT; i++) staged_words[i] = '0;
        load_commands(scmt_pkg::WORD_COUNT);
        repeat (10) send_random_line();
        drain_results();
        // a single active word
        load_random_commands();
        load_commands(1);
        repeat (10) send_random_line();
        drain_results();
    endtask

    task automatic test_random_traffic();
        load_random_commands();
        while (bytes_used < ITEM_TARGET) begin
            if ($urandom_range(24, 0) == 0) begin
                send_fast = ($urandom_range(3, 0) == 0);
                recv_fast = ($urandom_range(3, 0) == 0);
            end
            if ($urandom_range(39, 0) == 0) drain_results();
            if ($urandom_range(29, 0) == 0) begin
                drain_results();
                load_random_commands();
            end
            if ($urandom_range(19, 0) < 17) begin
                send_random_line();
            end else begin
                // noise, line ends frequent
                repeat ($urandom_range(8, 1)) begin
                    if ($urandom_range(3, 0) == 0) send_byte(scmt_pkg::END_CHAR);
                    else send_byte(8'($urandom_range(255, 0)));
                end
            end
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_rx_byte  = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        mismatches = 0;
        bytes_used = 0;
        send_fast  = 1'b0;
        recv_fast  = 1'b0;
        active_count = '0;
        for (int i = 0; i < scmt_pkg::WORD_COUNT; i++) command_words[i] = '0;
        clear_line();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_directed_lines();
        test_line_overflow();
        test_command_settings();
        test_random_traffic();

        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
